// ===== src/sale_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the suffix array / lcp engine
// no dependencies

package sale_pkg;

  localparam int MaxTextDef    = 1024;
  localparam int MaxPatternDef = 64;

  localparam int FuncW   = 2;
  localparam int SymW    = 8;
  localparam int RankW   = 11;
  localparam int CountW  = 20;
  localparam int TextW   = SymW + 1;
  localparam int SymBins = 257;

  localparam logic [FuncW-1:0] FUNC_TEXT    = 2'd0;
  localparam logic [FuncW-1:0] FUNC_PATTERN = 2'd1;
  localparam logic [FuncW-1:0] FUNC_READ    = 2'd2;

  typedef enum logic [1:0] {
    KIND_BUILD = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_ENTRY = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [SymW-1:0]  symbol;
    logic             last;
    logic [RankW-1:0] rank_index;
  } cmd_t;

  typedef struct packed {
    kind_e             kind;
    logic [RankW-1:0]  suffix_start;
    logic [RankW-1:0]  common_prefix;
    logic [CountW-1:0] count;
    logic              overflow;
  } res_t;

endpackage

// ===== src/sale_ifs.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for command and result transactions
// depends on sale_pkg

interface sale_cmd_if import sale_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [SymW-1:0]  symbol;
  logic             last;
  logic [RankW-1:0] rank_index;

  modport source (output valid, func, symbol, last, rank_index, input ready);
  modport sink (input valid, func, symbol, last, rank_index, output ready);
endinterface

interface sale_res_if import sale_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [RankW-1:0]  suffix_start;
  logic [RankW-1:0]  common_prefix;
  logic [CountW-1:0] count;
  logic              overflow;

  modport source (output valid, kind, suffix_start, common_prefix, count, overflow,
                  input ready);
  modport sink (input valid, kind, suffix_start, common_prefix, count, overflow,
                output ready);
endinterface

// ===== src/suffix_array_lcp_engine.sv =====
`timescale 1ns / 1ps
// top level of the suffix array / lcp engine: handshake and result register
// depends on sale_pkg, sale_ifs and sale_core

// Text bytes, pattern bytes and rank reads arrive as command transactions; at
// most one result transaction comes back per command. A non-final text or
// pattern byte is taken while the sequencer stays idle and gives no result.
// The final text byte appends a sentinel and starts the build, which runs on
// one sequencer with a single read and a single write port per memory: an
// initial symbol counting sort with first ranking, then ceil(log2 n) doubling
// rounds, at least one (rotate, bucket clear, histogram, prefix sum, scatter,
// rerank, copy back), then the kasai scan, where n is the text length plus
// one. The result carries the distinct substring total. Once a build is done,
// a final pattern byte runs two binary searches of about log2(n)+1 probes
// each; a probe reads a suffix start and then compares text and pattern bytes
// in order. The block takes no command while a build, a search or a read is
// under way or while a result waits in the output register. No clearing pass
// follows reset.

module suffix_array_lcp_engine import sale_pkg::*; #(
  parameter int MaxText    = MaxTextDef,
  parameter int MaxPattern = MaxPatternDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sale_cmd_if.sink   cmd_i,
  sale_res_if.source res_o
);

  cmd_t cmd;
  res_t core_res;
  res_t res_q;
  logic core_idle;
  logic core_res_valid;
  logic cmd_fire;
  logic out_valid_q;

  // accept only when the sequencer is idle and the result register is empty
  assign cmd_i.ready = core_idle && !out_valid_q;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;

  assign cmd.func       = cmd_i.func;
  assign cmd.symbol     = cmd_i.symbol;
  assign cmd.last       = cmd_i.last;
  assign cmd.rank_index = cmd_i.rank_index;

  sale_core #(
    .MaxText(MaxText),
    .MaxPattern(MaxPattern)
  ) u_core (
    .clk_i,
    .rst_ni,
    .cmd_valid_i(cmd_fire),
    .cmd_i(cmd),
    .idle_o(core_idle),
    .res_valid_o(core_res_valid),
    .res_o(core_res)
  );

  // output register: loaded when the sequencer finishes, freed on transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_res_valid) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_res_valid) begin
      res_q <= core_res;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.kind          = res_q.kind;
  assign res_o.suffix_start  = res_q.suffix_start;
  assign res_o.common_prefix = res_q.common_prefix;
  assign res_o.count         = res_q.count;
  assign res_o.overflow      = res_q.overflow;

  // a new result never lands on one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_res_valid |-> !out_valid_q)
    else $error("result produced while output register full");

  // while the sequencer works nothing sits in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !core_idle |-> !out_valid_q)
    else $error("output register full during sequencer work");

  // error results carry zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.kind == KIND_ERROR)) |->
      (res_q.suffix_start == '0 && res_q.common_prefix == '0 && res_q.count == '0))
    else $error("error result with nonzero payload");

endmodule

// ===== src/sale_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with one registered read port
// no dependencies

module sale_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sale_core.sv =====
`timescale 1ns / 1ps
// sequencer and shared datapath: prefix doubling sort, kasai lcp, pattern search
// depends on sale_pkg and sale_ram

module sale_core import sale_pkg::*; #(
  parameter int MaxText    = MaxTextDef,
  parameter int MaxPattern = MaxPatternDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic idle_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int Depth = MaxText + 1;
  localparam int AW    = $clog2(Depth);
  localparam int NW    = $clog2(MaxText + 2);
  localparam int BD    = (Depth > SymBins) ? Depth : SymBins;
  localparam int BW    = $clog2(BD);
  localparam int KW    = BW + 1;
  localparam int PAW   = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int PNW   = $clog2(MaxPattern + 1);
  localparam int SW    = $clog2(MaxText + MaxPattern + 2);
  localparam int CW    = (AW > RankW) ? AW : RankW;

  typedef enum logic [36:0] {
    S_IDLE = 37'd1 << 0,  S_RD1 = 37'd1 << 1,  S_SENT = 37'd1 << 2,
    S_BCLR = 37'd1 << 3,  S_HRD = 37'd1 << 4,  S_HBK = 37'd1 << 5,
    S_HWR = 37'd1 << 6,   S_PSR = 37'd1 << 7,  S_PSW = 37'd1 << 8,
    S_SCR = 37'd1 << 9,   S_SCK = 37'd1 << 10, S_SCB = 37'd1 << 11,
    S_SCW = 37'd1 << 12,  S_IR0 = 37'd1 << 13, S_IR1 = 37'd1 << 14,
    S_IR2 = 37'd1 << 15,  S_SH0 = 37'd1 << 16, S_SH1 = 37'd1 << 17,
    S_RR0 = 37'd1 << 18,  S_RR1 = 37'd1 << 19, S_RR2 = 37'd1 << 20,
    S_RR3 = 37'd1 << 21,  S_CP0 = 37'd1 << 22, S_CP1 = 37'd1 << 23,
    S_K0 = 37'd1 << 24,   S_K1 = 37'd1 << 25,  S_K2 = 37'd1 << 26,
    S_K3 = 37'd1 << 27,   S_K4 = 37'd1 << 28,  S_K5 = 37'd1 << 29,
    S_K6 = 37'd1 << 30,   S_K7 = 37'd1 << 31,  S_C1 = 37'd1 << 32,
    S_C2 = 37'd1 << 33,   S_C3 = 37'd1 << 34,  S_C4 = 37'd1 << 35,
    S_CD = 37'd1 << 36
  } state_e;

  state_e state_q, state_d;

  // memory ports
  logic             t_we;
  logic [AW-1:0]    t_wa, t_ra;
  logic [TextW-1:0] t_wd, t_rd;
  logic             s_we, r_we, o_we, q_we, l_we, b_we, p_we;
  logic [AW-1:0]    s_wa, s_wd, s_ra, s_rd;
  logic [AW-1:0]    r_wa, r_wd, r_ra, r_rd;
  logic [AW-1:0]    o_wa, o_wd, o_ra, o_rd;
  logic [AW-1:0]    q_wa, q_wd, q_ra, q_rd;
  logic [AW-1:0]    l_wa, l_wd, l_ra, l_rd;
  logic [BW-1:0]    b_wa, b_ra;
  logic [NW-1:0]    b_wd, b_rd;
  logic [PAW-1:0]   p_wa, p_ra;
  logic [SymW-1:0]  p_wd, p_rd;

  // datapath registers
  logic [AW-1:0]     len_q, len_d;
  logic [PNW-1:0]    plen_q, plen_d, t_q, t_d;
  logic              built_q, built_d, ovf_q, ovf_d, pdrop_q, pdrop_d;
  logic              init_q, init_d, second_q, second_d, lt_q, lt_d, eq_q, eq_d;
  logic [NW-1:0]     n_q, n_d, i_q, i_d, run_q, run_d, h_q, h_d;
  logic [NW-1:0]     lo_q, lo_d, hi_q, hi_d, lower_q, lower_d, m_q, m_d;
  logic [NW:0]       span_q, span_d;
  logic [KW-1:0]     k_q, k_d, lim_q, lim_d;
  logic [BW-1:0]     key_q, key_d;
  logic [AW-1:0]     v_q, v_d, rb_q, rb_d, pa_q, pa_d, pb_q, pb_d, pr_q, pr_d;
  logic [AW-1:0]     j_q, j_d, r_q, r_d, st_q, st_d;
  logic [TextW-1:0]  pt_q, pt_d, ta_q, ta_d;
  logic [CountW-1:0] total_q, total_d;

  // combinational helpers
  logic [AW-1:0]    eff_len, rank_val;
  logic [NW:0]      rot_s, wrap_s, ih, jh, lohi, span2;
  logic [SW-1:0]    st_t;
  logic [TextW-1:0] pat_sym;
  logic [2*NW-1:0]  prod;
  logic             pat_full, pat_drop, differ;

  sale_ram #(.Width(TextW), .Depth(Depth)) u_text (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(t_rd));
  sale_ram #(.Width(AW), .Depth(Depth)) u_sa (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd));
  sale_ram #(.Width(AW), .Depth(Depth)) u_rank (
    .clk_i, .we_i(r_we), .waddr_i(r_wa), .wdata_i(r_wd), .raddr_i(r_ra), .rdata_o(r_rd));
  sale_ram #(.Width(AW), .Depth(Depth)) u_osc (
    .clk_i, .we_i(o_we), .waddr_i(o_wa), .wdata_i(o_wd), .raddr_i(o_ra), .rdata_o(o_rd));
  sale_ram #(.Width(AW), .Depth(Depth)) u_rsc (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(q_wd), .raddr_i(q_ra), .rdata_o(q_rd));
  sale_ram #(.Width(AW), .Depth(Depth)) u_lcp (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(l_ra), .rdata_o(l_rd));
  sale_ram #(.Width(NW), .Depth(BD)) u_bkt (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i(b_wd), .raddr_i(b_ra), .rdata_o(b_rd));
  sale_ram #(.Width(SymW), .Depth(MaxPattern)) u_pat (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(p_ra), .rdata_o(p_rd));

  assign eff_len  = built_q ? '0 : len_q;
  assign rot_s    = (NW+1)'(s_rd) + (NW+1)'(n_q) - span_q;
  assign wrap_s   = (NW+1)'(v_q) + span_q;
  assign ih       = (NW+1)'(i_q) + (NW+1)'(h_q);
  assign jh       = (NW+1)'(j_q) + (NW+1)'(h_q);
  assign lohi     = (NW+1)'(lo_q) + (NW+1)'(hi_q);
  assign span2    = span_q << 1;
  assign st_t     = SW'(st_q) + SW'(t_q);
  assign pat_sym  = TextW'(p_rd) + TextW'(1);
  assign prod     = (2*NW)'(n_q) * (2*NW)'(n_q - NW'(1));
  assign pat_full = (plen_q >= PNW'(MaxPattern));
  assign pat_drop = pdrop_q | pat_full;
  assign differ   = (rb_q != pa_q) || (r_rd != pb_q);
  assign rank_val = (i_q == '0) ? '0 : pr_q + AW'(t_rd != pt_q);
  assign idle_o   = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    len_d = len_q;   plen_d = plen_q;   t_d = t_q;
    built_d = built_q; ovf_d = ovf_q;   pdrop_d = pdrop_q;
    init_d = init_q; second_d = second_q; lt_d = lt_q; eq_d = eq_q;
    n_d = n_q;       i_d = i_q;         run_d = run_q;   h_d = h_q;
    lo_d = lo_q;     hi_d = hi_q;       lower_d = lower_q; m_d = m_q;
    span_d = span_q; k_d = k_q;         lim_d = lim_q;   key_d = key_q;
    v_d = v_q;       rb_d = rb_q;       pa_d = pa_q;     pb_d = pb_q;
    pr_d = pr_q;     j_d = j_q;         r_d = r_q;       st_d = st_q;
    pt_d = pt_q;     ta_d = ta_q;       total_d = total_q;
    t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
    r_we = 1'b0; r_wa = '0; r_wd = '0; r_ra = '0;
    o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0;
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
    l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
    b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = '0;
    p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
    res_valid_o = 1'b0;
    res_o = '0;
    res_o.kind = KIND_ERROR;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.func)
            FUNC_TEXT: begin
              if (built_q) begin
                built_d = 1'b0;
                ovf_d   = 1'b0;
              end
              if (eff_len < AW'(MaxText)) begin
                t_we  = 1'b1;
                t_wa  = eff_len;
                t_wd  = TextW'(cmd_i.symbol) + TextW'(1);
                len_d = eff_len + AW'(1);
              end else begin
                len_d = eff_len;
                ovf_d = 1'b1;
              end
              if (cmd_i.last) begin
                state_d = S_SENT;
              end
            end
            FUNC_PATTERN: begin
              pdrop_d = pat_drop;
              if (!pat_full) begin
                p_we   = 1'b1;
                p_wa   = plen_q[PAW-1:0];
                p_wd   = cmd_i.symbol;
                plen_d = plen_q + PNW'(1);
              end
              if (cmd_i.last) begin
                if (built_q) begin
                  lo_d     = '0;
                  hi_d     = n_q;
                  second_d = 1'b0;
                  state_d  = S_C1;
                end else begin
                  res_valid_o    = 1'b1;
                  res_o.overflow = pat_drop;
                  plen_d         = '0;
                  pdrop_d        = 1'b0;
                end
              end
            end
            FUNC_READ: begin
              if (built_q && (CW'(cmd_i.rank_index) <= CW'(len_q))) begin
                s_ra    = AW'(cmd_i.rank_index);
                l_ra    = AW'(cmd_i.rank_index);
                state_d = S_RD1;
              end else begin
                res_valid_o = 1'b1;
              end
            end
            default: begin
              res_valid_o = 1'b1;
            end
          endcase
        end
      end
      S_RD1: begin
        res_valid_o         = 1'b1;
        res_o.kind          = KIND_ENTRY;
        res_o.suffix_start  = RankW'(s_rd);
        res_o.common_prefix = RankW'(l_rd);
        res_o.overflow      = ovf_q;
        state_d             = S_IDLE;
      end
      // sentinel, then symbol counting sort
      S_SENT: begin
        t_we    = 1'b1;
        t_wa    = len_q;
        n_d     = NW'(len_q) + NW'(1);
        init_d  = 1'b1;
        k_d     = '0;
        lim_d   = KW'(SymBins);
        state_d = S_BCLR;
      end
      S_BCLR: begin
        b_we = 1'b1;
        b_wa = k_q[BW-1:0];
        k_d  = k_q + KW'(1);
        if (k_q == lim_q - KW'(1)) begin
          i_d     = '0;
          state_d = S_HRD;
        end
      end
      S_HRD: begin
        if (i_q < n_q) begin
          t_ra    = i_q[AW-1:0];
          r_ra    = i_q[AW-1:0];
          state_d = S_HBK;
        end else begin
          k_d     = '0;
          run_d   = '0;
          state_d = S_PSR;
        end
      end
      S_HBK: begin
        key_d   = init_q ? BW'(t_rd) : BW'(r_rd);
        b_ra    = key_d;
        state_d = S_HWR;
      end
      S_HWR: begin
        b_we    = 1'b1;
        b_wa    = key_q;
        b_wd    = b_rd + NW'(1);
        i_d     = i_q + NW'(1);
        state_d = S_HRD;
      end
      S_PSR: begin
        if (k_q < lim_q) begin
          b_ra    = k_q[BW-1:0];
          state_d = S_PSW;
        end else begin
          i_d     = '0;
          state_d = S_SCR;
        end
      end
      S_PSW: begin
        b_we    = 1'b1;
        b_wa    = k_q[BW-1:0];
        b_wd    = run_q;
        run_d   = run_q + b_rd;
        k_d     = k_q + KW'(1);
        state_d = S_PSR;
      end
      S_SCR: begin
        if (i_q < n_q) begin
          t_ra    = i_q[AW-1:0];
          s_ra    = i_q[AW-1:0];
          state_d = init_q ? S_SCB : S_SCK;
        end else begin
          i_d     = '0;
          state_d = init_q ? S_IR0 : S_RR0;
        end
      end
      S_SCK: begin
        v_d     = s_rd;
        r_ra    = s_rd;
        state_d = S_SCB;
      end
      S_SCB: begin
        key_d   = init_q ? BW'(t_rd) : BW'(r_rd);
        b_ra    = key_d;
        state_d = S_SCW;
      end
      S_SCW: begin
        b_we    = 1'b1;
        b_wa    = key_q;
        b_wd    = b_rd + NW'(1);
        s_we    = init_q;
        s_wa    = b_rd[AW-1:0];
        s_wd    = i_q[AW-1:0];
        o_we    = !init_q;
        o_wa    = b_rd[AW-1:0];
        o_wd    = v_q;
        i_d     = i_q + NW'(1);
        state_d = S_SCR;
      end
      // first class ranks from symbols
      S_IR0: begin
        if (i_q < n_q) begin
          s_ra    = i_q[AW-1:0];
          state_d = S_IR1;
        end else begin
          init_d  = 1'b0;
          span_d  = (NW+1)'(1);
          i_d     = '0;
          state_d = S_SH0;
        end
      end
      S_IR1: begin
        v_d     = s_rd;
        t_ra    = s_rd;
        state_d = S_IR2;
      end
      S_IR2: begin
        r_we    = 1'b1;
        r_wa    = v_q;
        r_wd    = rank_val;
        pr_d    = rank_val;
        pt_d    = t_rd;
        i_d     = i_q + NW'(1);
        state_d = S_IR0;
      end
      // doubling round: rotate, count, scatter, rerank, copy back
      S_SH0: begin
        if (i_q < n_q) begin
          s_ra    = i_q[AW-1:0];
          state_d = S_SH1;
        end else begin
          k_d     = '0;
          lim_d   = KW'(n_q);
          state_d = S_BCLR;
        end
      end
      S_SH1: begin
        s_we    = 1'b1;
        s_wa    = i_q[AW-1:0];
        s_wd    = (rot_s >= (NW+1)'(n_q)) ? AW'(rot_s - (NW+1)'(n_q)) : AW'(rot_s);
        i_d     = i_q + NW'(1);
        state_d = S_SH0;
      end
      S_RR0: begin
        if (i_q < n_q) begin
          o_ra    = i_q[AW-1:0];
          state_d = S_RR1;
        end else begin
          i_d     = '0;
          state_d = S_CP0;
        end
      end
      S_RR1: begin
        s_we    = 1'b1;
        s_wa    = i_q[AW-1:0];
        s_wd    = o_rd;
        v_d     = o_rd;
        r_ra    = o_rd;
        state_d = S_RR2;
      end
      S_RR2: begin
        rb_d    = r_rd;
        r_ra    = (wrap_s >= (NW+1)'(n_q)) ? AW'(wrap_s - (NW+1)'(n_q)) : AW'(wrap_s);
        state_d = S_RR3;
      end
      S_RR3: begin
        q_we    = 1'b1;
        q_wa    = v_q;
        q_wd    = (i_q == '0) ? '0 : pr_q + AW'(differ);
        pr_d    = q_wd;
        pa_d    = rb_q;
        pb_d    = r_rd;
        i_d     = i_q + NW'(1);
        state_d = S_RR0;
      end
      S_CP0: begin
        if (i_q < n_q) begin
          q_ra    = i_q[AW-1:0];
          state_d = S_CP1;
        end else begin
          span_d = span2;
          i_d    = '0;
          if (span2 < (NW+1)'(n_q)) begin
            state_d = S_SH0;
          end else begin
            state_d = S_K0;
          end
        end
      end
      S_CP1: begin
        r_we    = 1'b1;
        r_wa    = i_q[AW-1:0];
        r_wd    = q_rd;
        i_d     = i_q + NW'(1);
        state_d = S_CP0;
      end
      // kasai lcp scan, distinct count kept as a running total
      S_K0: begin
        l_we    = 1'b1;
        total_d = CountW'(prod >> 1);
        h_d     = '0;
        i_d     = '0;
        state_d = S_K1;
      end
      S_K1: begin
        if ((NW+1)'(i_q) + (NW+1)'(1) < (NW+1)'(n_q)) begin
          r_ra    = i_q[AW-1:0];
          state_d = S_K2;
        end else begin
          res_valid_o    = 1'b1;
          res_o.kind     = KIND_BUILD;
          res_o.count    = total_q;
          res_o.overflow = ovf_q;
          built_d        = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_K2: begin
        r_d = r_rd;
        if (r_rd == '0) begin
          h_d     = '0;
          i_d     = i_q + NW'(1);
          state_d = S_K1;
        end else begin
          s_ra    = r_rd - AW'(1);
          state_d = S_K3;
        end
      end
      S_K3: begin
        j_d     = s_rd;
        state_d = S_K4;
      end
      S_K4: begin
        if ((ih < (NW+1)'(n_q)) && (jh < (NW+1)'(n_q))) begin
          t_ra    = AW'(ih);
          state_d = S_K5;
        end else begin
          state_d = S_K7;
        end
      end
      S_K5: begin
        ta_d    = t_rd;
        t_ra    = AW'(jh);
        state_d = S_K6;
      end
      S_K6: begin
        if (ta_q == t_rd) begin
          h_d     = h_q + NW'(1);
          state_d = S_K4;
        end else begin
          state_d = S_K7;
        end
      end
      S_K7: begin
        l_we    = 1'b1;
        l_wa    = r_q;
        l_wd    = AW'(h_q);
        total_d = total_q - CountW'(h_q);
        h_d     = (h_q != '0) ? h_q - NW'(1) : '0;
        i_d     = i_q + NW'(1);
        state_d = S_K1;
      end
      // two binary searches for the pattern range
      S_C1: begin
        if (lo_q < hi_q) begin
          m_d     = NW'(lohi >> 1);
          s_ra    = m_d[AW-1:0];
          state_d = S_C2;
        end else if (!second_q) begin
          lower_d  = lo_q;
          hi_d     = n_q;
          second_d = 1'b1;
        end else begin
          res_valid_o    = 1'b1;
          res_o.kind     = KIND_COUNT;
          res_o.count    = CountW'(lo_q - lower_q);
          res_o.overflow = pdrop_q;
          plen_d         = '0;
          pdrop_d        = 1'b0;
          state_d        = S_IDLE;
        end
      end
      S_C2: begin
        st_d    = s_rd;
        t_d     = '0;
        state_d = S_C3;
      end
      S_C3: begin
        if (t_q == plen_q) begin
          lt_d    = 1'b0;
          eq_d    = 1'b1;
          state_d = S_CD;
        end else if (st_t >= SW'(n_q)) begin
          lt_d    = 1'b1;
          eq_d    = 1'b0;
          state_d = S_CD;
        end else begin
          t_ra    = AW'(st_t);
          p_ra    = t_q[PAW-1:0];
          state_d = S_C4;
        end
      end
      S_C4: begin
        if (t_rd < pat_sym) begin
          lt_d    = 1'b1;
          eq_d    = 1'b0;
          state_d = S_CD;
        end else if (t_rd > pat_sym) begin
          lt_d    = 1'b0;
          eq_d    = 1'b0;
          state_d = S_CD;
        end else begin
          t_d     = t_q + PNW'(1);
          state_d = S_C3;
        end
      end
      S_CD: begin
        if (lt_q || (second_q && eq_q)) begin
          lo_d = m_q + NW'(1);
        end else begin
          hi_d = m_q;
        end
        state_d = S_C1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      len_q    <= '0;
      plen_q   <= '0;
      built_q  <= 1'b0;
      ovf_q    <= 1'b0;
      pdrop_q  <= 1'b0;
      init_q   <= 1'b0;
      second_q <= 1'b0;
      n_q      <= '0;
      i_q      <= '0;
      k_q      <= '0;
      lim_q    <= '0;
      span_q   <= '0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      plen_q   <= plen_d;
      built_q  <= built_d;
      ovf_q    <= ovf_d;
      pdrop_q  <= pdrop_d;
      init_q   <= init_d;
      second_q <= second_d;
      n_q      <= n_d;
      i_q      <= i_d;
      k_q      <= k_d;
      lim_q    <= lim_d;
      span_q   <= span_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    lt_q    <= lt_d;
    eq_q    <= eq_d;
    run_q   <= run_d;
    h_q     <= h_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    lower_q <= lower_d;
    m_q     <= m_d;
    key_q   <= key_d;
    v_q     <= v_d;
    rb_q    <= rb_d;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    pr_q    <= pr_d;
    j_q     <= j_d;
    r_q     <= r_d;
    st_q    <= st_d;
    pt_q    <= pt_d;
    ta_q    <= ta_d;
    total_q <= total_d;
  end

endmodule
